// ----- design/gtlb_pkg.sv -----
package gtlb_pkg;

    localparam int MAX_GLYPHS = 4096;
    localparam int MAX_BYTES  = 65536;

    localparam int GLYPH_W = 13;
    localparam int BYTE_W  = 16;
    localparam int WIDTH_W = 24;
    localparam int ADV_W   = 16;
    localparam int MET_W   = 16;
    localparam int CFG_W   = 24;

    localparam logic [GLYPH_W-1:0] GLYPH_SAT = GLYPH_W'(MAX_GLYPHS);
    localparam logic [BYTE_W-1:0]  BYTE_SAT  = BYTE_W'(MAX_BYTES - 1);
    localparam logic [WIDTH_W-1:0] WIDTH_SAT = {WIDTH_W{1'b1}};

    // character class codes
    localparam logic [1:0] CLS_ORDINARY = 2'd0;
    localparam logic [1:0] CLS_BREAK    = 2'd1;
    localparam logic [1:0] CLS_NEWLINE  = 2'd2;

    // configuration register indexes
    localparam logic CFG_WRAP_ENABLE = 1'b0;
    localparam logic CFG_MAX_WIDTH   = 1'b1;

    // ascent, descent, height
    typedef logic [2:0][MET_W-1:0] t_metrics;

    typedef struct packed {
        logic [GLYPH_W-1:0] start_glyph;
        logic [GLYPH_W-1:0] glyph_count;
        logic [BYTE_W-1:0]  start_byte;
        logic [BYTE_W-1:0]  byte_count;
        logic [WIDTH_W-1:0] line_width;
        t_metrics           metrics;
        logic               last_line;
    } t_line_rec;

    function automatic t_metrics metric_max(input t_metrics a, input t_metrics b);
        t_metrics r;
        for (int k = 0; k < 3; k++) begin
            r[k] = (a[k] > b[k]) ? a[k] : b[k];
        end
        return r;
    endfunction

    function automatic logic [GLYPH_W-1:0] glyph_sub0(input logic [GLYPH_W-1:0] a,
                                                      input logic [GLYPH_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    function automatic logic [BYTE_W-1:0] byte_sub0(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    function automatic logic [WIDTH_W-1:0] width_sat(input logic [WIDTH_W:0] v);
        return v[WIDTH_W] ? WIDTH_SAT : v[WIDTH_W-1:0];
    endfunction

    function automatic logic [GLYPH_W-1:0] glyph_inc(input logic [GLYPH_W-1:0] v);
        return (v >= GLYPH_SAT) ? GLYPH_SAT : (v + 1'b1);
    endfunction

    function automatic logic [BYTE_W-1:0] byte_inc(input logic [BYTE_W-1:0] v);
        return (v >= BYTE_SAT) ? BYTE_SAT : (v + 1'b1);
    endfunction

endpackage

// ----- design/greedy_text_line_breaker.sv -----
// Greedy word-wrap line breaker. Shaped glyphs enter one transaction at a time
// on the input channel, in text order; line records leave on the output channel.
// A newline glyph ends the line (the newline itself is excluded), a break glyph
// (space, hyphen, tab) sets a break point just after itself, and with
// wrap_enable set and max_width nonzero a glyph that pushes a non-empty line past
// max_width cuts it at the last break point, or before that glyph if there is
// none. The final glyph flushes the open line and, with ends_newline, an empty
// trailing line; last_line marks the last record of a text and all line state
// then returns to reset. Rate: one glyph per cycle unless the input stalls.
// A glyph is registered at the input, then its records enter a four-entry result
// queue; one glyph can produce up to three records, and the output channel moves
// one record per cycle unless i_out_stall holds it. The input stalls whenever the
// queue has under three free entries, so records per cycle at the output bound
// the sustained glyph rate. Write the configuration only while the block is idle.
module greedy_text_line_breaker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [gtlb_pkg::CFG_W-1:0]   i_cfg_data,
    // glyph input channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [gtlb_pkg::ADV_W-1:0]   i_advance,
    input  logic [gtlb_pkg::BYTE_W-1:0]  i_byte_index,
    input  logic [1:0]                   i_char_class,
    input  logic [gtlb_pkg::MET_W-1:0]   i_glyph_ascent,
    input  logic [gtlb_pkg::MET_W-1:0]   i_glyph_descent,
    input  logic [gtlb_pkg::MET_W-1:0]   i_glyph_height,
    input  logic                         i_final_glyph,
    input  logic [gtlb_pkg::BYTE_W-1:0]  i_total_bytes,
    input  logic                         i_ends_newline,
    // line record output channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [gtlb_pkg::GLYPH_W-1:0] o_start_glyph,
    output logic [gtlb_pkg::GLYPH_W-1:0] o_glyph_count,
    output logic [gtlb_pkg::BYTE_W-1:0]  o_start_byte,
    output logic [gtlb_pkg::BYTE_W-1:0]  o_byte_count,
    output logic [gtlb_pkg::WIDTH_W-1:0] o_line_width,
    output logic [gtlb_pkg::MET_W-1:0]   o_line_ascent,
    output logic [gtlb_pkg::MET_W-1:0]   o_line_descent,
    output logic [gtlb_pkg::MET_W-1:0]   o_line_height,
    output logic                         o_last_line
);
    import gtlb_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam int MAX_PUSH = 3;

    // ---------------- configuration ----------------
    logic               r_wrap_enable;
    logic [WIDTH_W-1:0] r_max_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_enable <= 1'b0;
            r_max_width   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WRAP_ENABLE: r_wrap_enable <= i_cfg_data[0];
                CFG_MAX_WIDTH:   r_max_width   <= i_cfg_data[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic               r_in_valid;
    logic [ADV_W-1:0]   r_advance;
    logic [BYTE_W-1:0]  r_byte_index;
    logic [1:0]         r_char_class;
    t_metrics           r_glyph_met;
    logic               r_final_glyph;
    logic [BYTE_W-1:0]  r_total_bytes;
    logic               r_ends_newline;

    // ---------------- result queue ----------------
    t_line_rec          r_queue [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_q_count;

    logic room;
    logic proc;
    logic pop;

    // Take a glyph only when the queue can absorb the worst case of three records.
    assign room       = (r_q_count <= QCNT_W'(QDEPTH - MAX_PUSH));
    assign proc       = r_in_valid && room;
    assign o_in_stall = r_in_valid && !room;
    assign pop        = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_advance      <= i_advance;
            r_byte_index   <= i_byte_index;
            r_char_class   <= i_char_class;
            r_glyph_met    <= {i_glyph_height, i_glyph_descent, i_glyph_ascent};
            r_final_glyph  <= i_final_glyph;
            r_total_bytes  <= i_total_bytes;
            r_ends_newline <= i_ends_newline;
        end
    end

    // ---------------- line state ----------------
    logic [GLYPH_W-1:0] r_glyph_counter;
    logic [GLYPH_W-1:0] r_line_first_glyph;
    logic [BYTE_W-1:0]  r_line_first_byte;
    logic [WIDTH_W-1:0] r_running_width;
    logic [GLYPH_W-1:0] r_break_glyph;
    logic [BYTE_W-1:0]  r_break_byte;
    logic [WIDTH_W-1:0] r_width_at_break;
    logic [GLYPH_W-1:0] r_glyphs_on_line;
    t_metrics           r_met_before;
    t_metrics           r_met_after;

    logic [GLYPH_W-1:0] n_glyph_counter;
    logic [GLYPH_W-1:0] n_line_first_glyph;
    logic [BYTE_W-1:0]  n_line_first_byte;
    logic [WIDTH_W-1:0] n_running_width;
    logic [GLYPH_W-1:0] n_break_glyph;
    logic [BYTE_W-1:0]  n_break_byte;
    logic [WIDTH_W-1:0] n_width_at_break;
    logic [GLYPH_W-1:0] n_glyphs_on_line;
    t_metrics           n_met_before;
    t_metrics           n_met_after;

    // records produced by this glyph: line end (newline or wrap), flush, trailing
    t_line_rec rec_end, rec_flush, rec_trail;
    logic      v_end, v_flush, v_trail;

    logic [GLYPH_W-1:0] next_glyph;
    logic [BYTE_W-1:0]  bi_inc;
    logic [WIDTH_W:0]   sum;
    logic               wrap;
    logic [GLYPH_W-1:0] s1_break_glyph;
    logic [BYTE_W-1:0]  s1_break_byte;
    logic [WIDTH_W-1:0] s1_width_at_break;
    t_metrics           s1_met_before;
    t_metrics           s1_met_after;
    logic [WIDTH_W:0]   carry_width;

    always_comb begin
        next_glyph = glyph_inc(r_glyph_counter);
        bi_inc     = byte_inc(r_byte_index);
        sum        = {1'b0, r_running_width} + (WIDTH_W+1)'(r_advance);

        // hold state by default
        n_glyph_counter    = r_glyph_counter;
        n_line_first_glyph = r_line_first_glyph;
        n_line_first_byte  = r_line_first_byte;
        n_running_width    = r_running_width;
        n_break_glyph      = r_break_glyph;
        n_break_byte       = r_break_byte;
        n_width_at_break   = r_width_at_break;
        n_glyphs_on_line   = r_glyphs_on_line;
        n_met_before       = r_met_before;
        n_met_after        = r_met_after;

        s1_break_glyph    = r_break_glyph;
        s1_break_byte     = r_break_byte;
        s1_width_at_break = r_width_at_break;
        s1_met_before     = r_met_before;
        s1_met_after      = r_met_after;
        carry_width       = '0;
        wrap              = 1'b0;

        rec_end = '0;
        v_end   = 1'b0;

        if (r_char_class == CLS_NEWLINE) begin
            // close the line, newline excluded
            v_end               = 1'b1;
            rec_end.start_glyph = r_line_first_glyph;
            rec_end.glyph_count = glyph_sub0(r_glyph_counter, r_line_first_glyph);
            rec_end.start_byte  = r_line_first_byte;
            rec_end.byte_count  = byte_sub0(r_byte_index, r_line_first_byte);
            rec_end.line_width  = r_running_width;
            rec_end.metrics     = metric_max(metric_max(r_met_before, r_met_after),
                                             r_glyph_met);
            n_line_first_glyph  = next_glyph;
            n_line_first_byte   = bi_inc;
            n_running_width     = '0;
            n_break_glyph       = next_glyph;
            n_break_byte        = bi_inc;
            n_width_at_break    = '0;
            n_glyphs_on_line    = '0;
            n_met_before        = '0;
            n_met_after         = '0;
        end else begin
            // break glyph: move the break point just after itself
            if (r_char_class == CLS_BREAK) begin
                s1_break_glyph    = next_glyph;
                s1_break_byte     = bi_inc;
                s1_width_at_break = width_sat(sum);
                s1_met_before     = metric_max(metric_max(r_met_before, r_met_after),
                                               r_glyph_met);
                s1_met_after      = '0;
            end else begin
                s1_met_after = metric_max(r_met_after, r_glyph_met);
            end

            wrap = r_wrap_enable && (r_max_width != '0)
                && (sum > {1'b0, r_max_width}) && (r_glyphs_on_line != '0);

            n_met_after = s1_met_after;

            if (wrap) begin
                v_end = 1'b1;
                if (s1_break_glyph > r_line_first_glyph) begin
                    // cut at the break point, carry the rest
                    rec_end.start_glyph = r_line_first_glyph;
                    rec_end.glyph_count = s1_break_glyph - r_line_first_glyph;
                    rec_end.start_byte  = r_line_first_byte;
                    rec_end.byte_count  = byte_sub0(s1_break_byte, r_line_first_byte);
                    rec_end.line_width  = s1_width_at_break;
                    rec_end.metrics     = s1_met_before;
                    n_glyphs_on_line    = glyph_sub0(next_glyph, s1_break_glyph);
                    n_line_first_glyph  = s1_break_glyph;
                    n_line_first_byte   = s1_break_byte;
                    if (sum > {1'b0, s1_width_at_break}) begin
                        carry_width = sum - {1'b0, s1_width_at_break};
                    end
                    n_running_width     = width_sat(carry_width);
                end else begin
                    // no break point: cut before this glyph
                    rec_end.start_glyph = r_line_first_glyph;
                    rec_end.glyph_count = glyph_sub0(r_glyph_counter, r_line_first_glyph);
                    rec_end.start_byte  = r_line_first_byte;
                    rec_end.byte_count  = byte_sub0(r_byte_index, r_line_first_byte);
                    rec_end.line_width  = r_running_width;
                    rec_end.metrics     = metric_max(s1_met_before, r_met_after);
                    n_line_first_glyph  = r_glyph_counter;
                    n_line_first_byte   = r_byte_index;
                    n_running_width     = WIDTH_W'(r_advance);
                    n_met_after         = r_glyph_met;
                    n_glyphs_on_line    = GLYPH_W'(1);
                end
                n_met_before     = '0;
                n_break_glyph    = n_line_first_glyph;
                n_break_byte     = n_line_first_byte;
                n_width_at_break = '0;
            end else begin
                n_break_glyph    = s1_break_glyph;
                n_break_byte     = s1_break_byte;
                n_width_at_break = s1_width_at_break;
                n_met_before     = s1_met_before;
                n_running_width  = width_sat(sum);
                n_glyphs_on_line = glyph_inc(r_glyphs_on_line);
            end
        end

        n_glyph_counter = next_glyph;

        // final glyph: flush the open line and the optional trailing empty line
        v_flush               = r_final_glyph && (n_line_first_glyph < next_glyph);
        rec_flush.start_glyph = n_line_first_glyph;
        rec_flush.glyph_count = next_glyph - n_line_first_glyph;
        rec_flush.start_byte  = n_line_first_byte;
        rec_flush.byte_count  = byte_sub0(r_total_bytes, n_line_first_byte);
        rec_flush.line_width  = n_running_width;
        rec_flush.metrics     = metric_max(n_met_before, n_met_after);
        rec_flush.last_line   = r_final_glyph && !(r_final_glyph && r_ends_newline);

        v_trail               = r_final_glyph && r_ends_newline;
        rec_trail.start_glyph = next_glyph;
        rec_trail.glyph_count = '0;
        rec_trail.start_byte  = r_total_bytes;
        rec_trail.byte_count  = '0;
        rec_trail.line_width  = '0;
        rec_trail.metrics     = r_glyph_met;
        rec_trail.last_line   = 1'b1;

        rec_end.last_line = r_final_glyph && !v_flush && !v_trail;

        if (r_final_glyph) begin
            n_glyph_counter    = '0;
            n_line_first_glyph = '0;
            n_line_first_byte  = '0;
            n_running_width    = '0;
            n_break_glyph      = '0;
            n_break_byte       = '0;
            n_width_at_break   = '0;
            n_glyphs_on_line   = '0;
            n_met_before       = '0;
            n_met_after        = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_counter    <= '0;
            r_line_first_glyph <= '0;
            r_line_first_byte  <= '0;
            r_running_width    <= '0;
            r_break_glyph      <= '0;
            r_break_byte       <= '0;
            r_width_at_break   <= '0;
            r_glyphs_on_line   <= '0;
            r_met_before       <= '0;
            r_met_after        <= '0;
        end else if (proc) begin
            r_glyph_counter    <= n_glyph_counter;
            r_line_first_glyph <= n_line_first_glyph;
            r_line_first_byte  <= n_line_first_byte;
            r_running_width    <= n_running_width;
            r_break_glyph      <= n_break_glyph;
            r_break_byte       <= n_break_byte;
            r_width_at_break   <= n_width_at_break;
            r_glyphs_on_line   <= n_glyphs_on_line;
            r_met_before       <= n_met_before;
            r_met_after        <= n_met_after;
        end
    end

    // ---------------- queue write: pack the valid records in order ----------------
    logic [QPTR_W-1:0] off_flush;
    logic [QPTR_W-1:0] off_trail;
    logic [1:0]        n_push;

    always_comb begin
        off_flush = QPTR_W'(v_end);
        off_trail = QPTR_W'(v_end) + QPTR_W'(v_flush);
        n_push    = 2'(v_end) + 2'(v_flush) + 2'(v_trail);
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            if (v_end) begin
                r_queue[r_wr_ptr] <= rec_end;
            end
            if (v_flush) begin
                r_queue[r_wr_ptr + off_flush] <= rec_flush;
            end
            if (v_trail) begin
                r_queue[r_wr_ptr + off_trail] <= rec_trail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_q_count <= '0;
        end else begin
            if (proc) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(n_push);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_q_count <= r_q_count + (proc ? QCNT_W'(n_push) : '0)
                       - QCNT_W'(pop);
        end
    end

    // ---------------- output ----------------
    t_line_rec head;

    assign head           = r_queue[r_rd_ptr];
    assign o_out_valid    = (r_q_count != '0);
    assign o_start_glyph  = head.start_glyph;
    assign o_glyph_count  = head.glyph_count;
    assign o_start_byte   = head.start_byte;
    assign o_byte_count   = head.byte_count;
    assign o_line_width   = head.line_width;
    assign o_line_ascent  = head.metrics[0];
    assign o_line_descent = head.metrics[1];
    assign o_line_height  = head.metrics[2];
    assign o_last_line    = head.last_line;

endmodule
